[design/scms_pkg.sv]
// Shared types, codes and constants of the sector copy merge selector.
package scms_pkg;

	localparam int unsigned DEF_MAX_CYLINDERS   = 128;
	localparam int unsigned DEF_MAX_HEADS       = 2;
	localparam int unsigned DEF_MAX_SECTORS     = 32;
	localparam int unsigned DEF_MAX_REVOLUTIONS = 8;

	typedef enum logic [1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_MERGE  = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_UNMERGED = 2'd2;

	localparam logic [1:0] CLS_GOOD    = 2'd0;
	localparam logic [1:0] CLS_BAD     = 2'd1;
	localparam logic [1:0] CLS_MISSING = 2'd2;

	localparam logic [2:0] REG_CYLINDERS   = 3'd0;
	localparam logic [2:0] REG_HEADS       = 3'd1;
	localparam logic [2:0] REG_SECTORS     = 3'd2;
	localparam logic [2:0] REG_REVOLUTIONS = 3'd3;
	localparam logic [2:0] REG_BYTES       = 3'd4;

	localparam logic [7:0]  RST_CYLINDERS   = 8'd80;
	localparam logic [1:0]  RST_HEADS       = 2'd2;
	localparam logic [5:0]  RST_SECTORS     = 6'd11;
	localparam logic [3:0]  RST_REVOLUTIONS = 4'd1;
	localparam logic [12:0] RST_BYTES       = 13'd512;

	localparam int unsigned FLAG_USED   = 0;
	localparam int unsigned FLAG_CRC1   = 1;
	localparam int unsigned FLAG_CRC2   = 2;
	localparam int unsigned FLAG_MERGED = 3;

	localparam logic [13:0] CNT_MAX = 14'h3FFF;
	localparam logic [24:0] OFS_MAX = 25'h1FF_FFFF;

	typedef struct packed {
		logic capture;
		logic rd;
		logic scan;
		logic wr;
		logic clr;
		logic fin;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  req_ok;
		logic  scan_last;
		logic  clr_last;
	} sts_t;

endpackage

[design/scms_ram.sv]
// Generic single-port-write, registered-read RAM.
module scms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/scms_ctrl.sv]
// Controller state machine of the sector copy merge selector.
module scms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  scms_pkg::sts_t sts,
	output scms_pkg::cmd_t cmd
);
	import scms_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b000_0001,
		S_IDLE  = 7'b000_0010,
		S_RD    = 7'b000_0100,
		S_SCAN  = 7'b000_1000,
		S_WR    = 7'b001_0000,
		S_QW    = 7'b010_0000,
		S_FIN   = 7'b100_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (!sts.req_ok) begin
					state_d = S_FIN;
				end else begin
					unique case (sts.func)
						FUNC_RECORD: state_d = S_WR;
						FUNC_MERGE:  state_d = S_SCAN;
						FUNC_QUERY:  state_d = S_QW;
						default:     state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_WR;
				end
			end
			S_WR:    state_d = S_FIN;
			S_QW:    state_d = S_FIN;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.rd      = (state_q == S_RD);
	assign cmd.scan    = (state_q == S_SCAN);
	assign cmd.wr      = (state_q == S_WR);
	assign cmd.clr     = (state_q == S_CLEAR);
	assign cmd.fin     = (state_q == S_FIN);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_RD))
		else $error("accepted word did not start a table read");

	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> sts.req_ok)
		else $error("table written for a rejected request");

	a_scan_merge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (sts.func == FUNC_MERGE))
		else $error("copy scan running for a request that is not a merge");

endmodule

[design/scms_dp.sv]
// Datapath of the sector copy merge selector: registers, flag table, scan and offset.
module scms_dp #(
	parameter int unsigned MAX_CYLINDERS   = scms_pkg::DEF_MAX_CYLINDERS,
	parameter int unsigned MAX_HEADS       = scms_pkg::DEF_MAX_HEADS,
	parameter int unsigned MAX_SECTORS     = scms_pkg::DEF_MAX_SECTORS,
	parameter int unsigned MAX_REVOLUTIONS = scms_pkg::DEF_MAX_REVOLUTIONS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  scms_pkg::cmd_t cmd,
	output scms_pkg::sts_t sts,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [12:0]    cfg_data,
	input  logic [1:0]     func,
	input  logic [7:0]     cylinder,
	input  logic [7:0]     head,
	input  logic [7:0]     sector,
	input  logic [7:0]     revolution,
	input  logic           first_crc_good,
	input  logic           second_crc_good,
	output logic [1:0]     status,
	output logic [2:0]     chosen_revolution,
	output logic [1:0]     merge_class,
	output logic           sector_missing,
	output logic           sector_crc_bad,
	output logic [24:0]    byte_offset,
	output logic [13:0]    missing_total,
	output logic [13:0]    bad_total
);
	import scms_pkg::*;

	localparam int unsigned SECT_DEPTH = MAX_CYLINDERS * MAX_HEADS * MAX_SECTORS;
	localparam int unsigned SECT_AW    = (SECT_DEPTH > 1) ? $clog2(SECT_DEPTH) : 1;
	localparam int unsigned RIW        = (MAX_REVOLUTIONS > 1) ? $clog2(MAX_REVOLUTIONS) : 1;
	localparam int unsigned COPY_W     = 3 * MAX_REVOLUTIONS;
	localparam int unsigned ROW_W      = 4 + COPY_W;

	logic [7:0]  ncyl_q;
	logic [1:0]  nhead_q;
	logic [5:0]  nsec_q;
	logic [3:0]  nrev_q;
	logic [12:0] sbytes_q;

	func_t       func_q;
	logic [7:0]  cyl_q;
	logic [7:0]  head_q;
	logic [7:0]  sec_q;
	logic [7:0]  rev_q;
	logic        g1_q;
	logic        g2_q;

	logic [SECT_AW-1:0] clr_q;
	logic [SECT_AW-1:0] sect_idx;
	logic               lay_ok;
	logic               rev_ok;

	logic [ROW_W-1:0]                  rdata;
	logic [ROW_W-1:0]                  wr_row;
	logic [MAX_REVOLUTIONS-1:0][2:0]   copies;
	logic [MAX_REVOLUTIONS-1:0][2:0]   wr_copies;
	logic [3:0]                        merged;
	logic [3:0]                        wr_merged;

	logic [RIW-1:0] k_q;
	logic           found0_q;
	logic           found1_q;
	logic           found2_q;
	logic [RIW-1:0] sel0_q;
	logic [RIW-1:0] sel1_q;
	logic [RIW-1:0] sel2_q;
	logic [2:0]     flg1_q;
	logic [2:0]     cur;
	logic           k_valid;

	logic           m_found;
	logic [2:0]     m_flags;
	logic [RIW-1:0] m_sel;
	logic [1:0]     m_cls;

	logic [13:0] miss_cnt_q;
	logic [13:0] bad_cnt_q;

	logic [10:0] blk_s1;
	logic [17:0] blk_s2;
	logic [30:0] ofs_prod;
	logic [24:0] ofs_sat;

	logic [1:0]  status_q;
	logic [2:0]  chosen_q;
	logic [1:0]  cls_q;
	logic        miss_q;
	logic        bad_q;
	logic [24:0] ofs_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncyl_q   <= RST_CYLINDERS;
			nhead_q  <= RST_HEADS;
			nsec_q   <= RST_SECTORS;
			nrev_q   <= RST_REVOLUTIONS;
			sbytes_q <= RST_BYTES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CYLINDERS:   ncyl_q   <= cfg_data[7:0];
				REG_HEADS:       nhead_q  <= cfg_data[1:0];
				REG_SECTORS:     nsec_q   <= cfg_data[5:0];
				REG_REVOLUTIONS: nrev_q   <= cfg_data[3:0];
				REG_BYTES:       sbytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(func);
			cyl_q  <= cylinder;
			head_q <= head;
			sec_q  <= sector;
			rev_q  <= revolution;
			g1_q   <= first_crc_good;
			g2_q   <= second_crc_good;
		end
	end

	assign lay_ok = (cyl_q < ncyl_q) && (32'(cyl_q) < MAX_CYLINDERS)
		&& (head_q < {6'd0, nhead_q}) && (32'(head_q) < MAX_HEADS)
		&& (sec_q < {2'd0, nsec_q}) && (32'(sec_q) < MAX_SECTORS);
	assign rev_ok = (rev_q < {4'd0, nrev_q}) && (32'(rev_q) < MAX_REVOLUTIONS);

	assign sts.func      = func_q;
	assign sts.req_ok    = (func_q != FUNC_NONE) && lay_ok
		&& ((func_q != FUNC_RECORD) || rev_ok);
	assign sts.scan_last = (32'(k_q) + 32'd1 >= 32'(nrev_q))
		|| (32'(k_q) + 32'd1 >= MAX_REVOLUTIONS);
	assign sts.clr_last  = (32'(clr_q) == SECT_DEPTH - 1);

	assign sect_idx = SECT_AW'((32'(cyl_q) * MAX_HEADS + 32'(head_q)) * MAX_SECTORS
		+ 32'(sec_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign copies = rdata[COPY_W-1:0];
	assign merged = rdata[ROW_W-1 -: 4];

	always_comb begin
		wr_copies = copies;
		wr_merged = merged;
		if (func_q == FUNC_RECORD) begin
			wr_copies[rev_q[RIW-1:0]] = {g2_q, g1_q, 1'b1};
		end else begin
			wr_merged = {1'b1, m_flags};
		end
	end

	assign wr_row = cmd.clr ? '0 : {wr_merged, wr_copies};

	scms_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SECT_DEPTH),
		.AW    (SECT_AW)
	) u_table (
		.clk   (clk),
		.we    (cmd.clr || cmd.wr),
		.waddr (cmd.clr ? clr_q : sect_idx),
		.wdata (wr_row),
		.re    (cmd.rd),
		.raddr (sect_idx),
		.rdata (rdata)
	);

	assign cur     = copies[k_q];
	assign k_valid = (32'(k_q) < 32'(nrev_q)) && cur[FLAG_USED];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			found0_q <= 1'b0;
			found1_q <= 1'b0;
			found2_q <= 1'b0;
		end else if (cmd.rd) begin
			k_q      <= '0;
			found0_q <= 1'b0;
			found1_q <= 1'b0;
			found2_q <= 1'b0;
		end else if (cmd.scan) begin
			k_q <= k_q + 1'b1;
			if (k_valid) begin
				if (!found0_q && cur[FLAG_CRC1] && cur[FLAG_CRC2]) begin
					found0_q <= 1'b1;
				end
				if (!found1_q && (cur[FLAG_CRC1] || cur[FLAG_CRC2])) begin
					found1_q <= 1'b1;
				end
				found2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && k_valid) begin
			if (!found0_q && cur[FLAG_CRC1] && cur[FLAG_CRC2]) begin
				sel0_q <= k_q;
			end
			if (!found1_q && (cur[FLAG_CRC1] || cur[FLAG_CRC2])) begin
				sel1_q <= k_q;
				flg1_q <= cur;
			end
			if (!found2_q) begin
				sel2_q <= k_q;
			end
		end
	end

	always_comb begin
		m_found = 1'b1;
		m_flags = 3'b000;
		m_sel   = '0;
		m_cls   = CLS_BAD;
		if (found0_q) begin
			m_flags = 3'b111;
			m_sel   = sel0_q;
			m_cls   = CLS_GOOD;
		end else if (found1_q) begin
			m_flags = flg1_q;
			m_sel   = sel1_q;
		end else if (found2_q) begin
			m_flags = 3'b001;
			m_sel   = sel2_q;
		end else begin
			m_found = 1'b0;
			m_cls   = CLS_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_cnt_q <= '0;
			bad_cnt_q  <= '0;
		end else if (cmd.wr && (func_q == FUNC_MERGE)) begin
			if (!m_found) begin
				if (miss_cnt_q != CNT_MAX) begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (m_cls == CLS_BAD) begin
				if (bad_cnt_q != CNT_MAX) begin
					bad_cnt_q <= bad_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		blk_s1 <= 11'(cyl_q) * 11'(nhead_q) + 11'(head_q);
		blk_s2 <= 18'(blk_s1) * 18'(nsec_q) + 18'(sec_q);
	end

	assign ofs_prod = 31'(blk_s2) * 31'(sbytes_q);
	assign ofs_sat  = (ofs_prod > 31'(OFS_MAX)) ? OFS_MAX : ofs_prod[24:0];

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status_q <= ST_OK;
			chosen_q <= 3'd0;
			cls_q    <= CLS_GOOD;
			miss_q   <= 1'b0;
			bad_q    <= 1'b0;
			ofs_q    <= '0;
			if (!sts.req_ok) begin
				status_q <= ST_RANGE;
			end else begin
				case (func_q)
					FUNC_MERGE: begin
						chosen_q <= 3'(m_sel);
						cls_q    <= m_cls;
						miss_q   <= !m_found;
						bad_q    <= !(m_flags[FLAG_CRC1] && m_flags[FLAG_CRC2]);
						ofs_q    <= ofs_sat;
					end
					FUNC_QUERY: begin
						if (!merged[FLAG_MERGED]) begin
							status_q <= ST_UNMERGED;
						end else begin
							miss_q <= !merged[FLAG_USED];
							bad_q  <= !(merged[FLAG_CRC1] && merged[FLAG_CRC2]);
							ofs_q  <= ofs_sat;
							if (!merged[FLAG_USED]) begin
								cls_q <= CLS_MISSING;
							end else if (!(merged[FLAG_CRC1] && merged[FLAG_CRC2])) begin
								cls_q <= CLS_BAD;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign status            = status_q;
	assign chosen_revolution = chosen_q;
	assign merge_class       = cls_q;
	assign sector_missing    = miss_q;
	assign sector_crc_bad    = bad_q;
	assign byte_offset       = ofs_q;
	assign missing_total     = miss_cnt_q;
	assign bad_total         = bad_cnt_q;

endmodule

[design/sector_copy_merge_selector.sv]
// Top level of the sector copy merge selector.
//
// A request word is taken when start is high and busy is low. func selects
// recording a copy's CRC flags, merging one sector over its revolution
// copies, or querying a merged sector with its byte offset in the image.
// Each request gives exactly one result word, shown for one cycle with done
// high; the receiver cannot stall and must take it in that cycle.
// A record passes the read, write and finish states, a query the read, query
// wait and finish states; done is registered from the finish state. A merge
// scans between read and write, one copy of the table row per cycle: the
// revolution count in effect, at least one and at most MAX_REVOLUTIONS copies.
// A rejected request goes from read to finish; one item is handled at a time.
// Layout registers are written through the cfg channel, which is always
// ready; they should only be changed while the block is idle.
// After reset the flag table is cleared one sector row per cycle, which
// covers all MAX_CYLINDERS * MAX_HEADS * MAX_SECTORS rows (8192 by default);
// busy stays high until the clearing pass is over.
module sector_copy_merge_selector #(
	parameter int unsigned MAX_CYLINDERS   = scms_pkg::DEF_MAX_CYLINDERS,
	parameter int unsigned MAX_HEADS       = scms_pkg::DEF_MAX_HEADS,
	parameter int unsigned MAX_SECTORS     = scms_pkg::DEF_MAX_SECTORS,
	parameter int unsigned MAX_REVOLUTIONS = scms_pkg::DEF_MAX_REVOLUTIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  cylinder,
	input  logic [7:0]  head,
	input  logic [7:0]  sector,
	input  logic [7:0]  revolution,
	input  logic        first_crc_good,
	input  logic        second_crc_good,
	output logic        done,
	output logic [1:0]  status,
	output logic [2:0]  chosen_revolution,
	output logic [1:0]  merge_class,
	output logic        sector_missing,
	output logic        sector_crc_bad,
	output logic [24:0] byte_offset,
	output logic [13:0] missing_total,
	output logic [13:0] bad_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import scms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	scms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	scms_dp #(
		.MAX_CYLINDERS   (MAX_CYLINDERS),
		.MAX_HEADS       (MAX_HEADS),
		.MAX_SECTORS     (MAX_SECTORS),
		.MAX_REVOLUTIONS (MAX_REVOLUTIONS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.func              (func),
		.cylinder          (cylinder),
		.head              (head),
		.sector            (sector),
		.revolution        (revolution),
		.first_crc_good    (first_crc_good),
		.second_crc_good   (second_crc_good),
		.status            (status),
		.chosen_revolution (chosen_revolution),
		.merge_class       (merge_class),
		.sector_missing    (sector_missing),
		.sector_crc_bad    (sector_crc_bad),
		.byte_offset       (byte_offset),
		.missing_total     (missing_total),
		.bad_total         (bad_total)
	);

endmodule
